/* sv/positional_insert_remove_buffer_unit_macros.svh */
// Assertion macros for the positional insert/remove buffer.
// Included by the top level; assertions vanish when SYNTHESIS is defined.
`ifndef POSITIONAL_INSERT_REMOVE_BUFFER_UNIT_MACROS_SVH
`define POSITIONAL_INSERT_REMOVE_BUFFER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define PIRB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pirb assertion failed");

`define PIRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pirb assertion failed");

`else

`define PIRB_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define PIRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/pirb_pkg.sv */
// Shared types and codes for the positional insert/remove buffer.
// Used by the cell row and the top level; depends on nothing.
package pirb_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_ASSIGN = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [7:0] POS_APPEND = -8'sd1;

    localparam int unsigned RESULT_POS_W = 7;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [7:0] data;
    } cell_ctrl_t;

endpackage

/* sv/pirb_if.sv */
// Valid/ready channel interfaces for the positional insert/remove buffer.
// The request carries a command; the response carries its result.
interface pirb_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic signed [7:0] position;
    logic [7:0]        data_in;

    modport source (output valid, output command, output position, output data_in,
                    input ready);
    modport sink   (input valid, input command, input position, input data_in,
                    output ready);
endinterface

interface pirb_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] resolved_position;
    logic [7:0] data_out;
    logic [6:0] count;

    modport source (output valid, output status, output resolved_position,
                    output data_out, output count, input ready);
    modport sink   (input valid, input status, input resolved_position,
                    input data_out, input count, output ready);
endinterface

/* sv/positional_insert_remove_buffer_unit.sv */
// Top level of the positional insert/remove buffer: command decode, fill count,
// result register and the row of storage cells. Depends on pirb_pkg, pirb_if, pirb_cell.
//
// On each request the row of cells shifts every stored byte from the position on up or
// down in parallel, so an insert or remove in the middle costs the same as an append,
// and a new request is taken in every cycle while the response side keeps up. The
// response is loaded into a register as its request is taken; the request side stays
// ready while that register is empty or being drained. Stored bytes have no reset and
// no clearing pass; only fill count and response valid are cleared. Positions past the
// count (or at it, but for insert) are out of range; resolved position/count are 7 bits.
`include "positional_insert_remove_buffer_unit_macros.svh"

module positional_insert_remove_buffer_unit
    import pirb_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    pirb_req_if.sink    req,
    pirb_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic [6:0]       resolved_reg;
    logic [7:0]       data_out_reg;
    logic [6:0]       count_reg;

    logic             accept;
    logic             pos_neg;
    logic             pos_append;
    logic [CW-1:0]    pos_u;
    logic [CW-1:0]    cnt;
    logic [CW-1:0]    where;
    logic [CW-1:0]    fill_next_cw;
    logic             full;
    logic [1:0]       status_c;
    logic             ok;
    cell_ctrl_t       ctrl;
    logic [7:0]       rd_c;

    logic [7:0]       cell_data [CAPACITY];
    logic [7:0]       cell_tap  [CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_neg    = req.position[7];
    assign pos_append = (req.position == POS_APPEND);
    assign pos_u      = CW'(req.position[6:0]);
    assign cnt        = CW'(fill_reg);
    assign full       = (fill_reg == CNT_W'(CAPACITY));
    assign where      = pos_append ? cnt : pos_u;

    always_comb
    begin
        status_c = ST_OK;
        if (req.command == CMD_INSERT)
        begin
            if (!(pos_append || (!pos_neg && pos_u <= cnt)))
            begin
                status_c = ST_RANGE;
            end
            else if (full)
            begin
                status_c = ST_FULL;
            end
        end
        else if (pos_neg || pos_u >= cnt)
        begin
            status_c = ST_RANGE;
        end
    end

    assign ok = (status_c == ST_OK);

    always_comb
    begin
        ctrl.data = req.data_in;
        ctrl.op   = CELL_HOLD;
        fill_next = fill_reg;
        if (accept && ok)
        begin
            case (req.command)
                CMD_INSERT:
                begin
                    ctrl.op   = CELL_SHIFT_UP;
                    fill_next = fill_reg + 1'b1;
                end
                CMD_REMOVE:
                begin
                    ctrl.op   = CELL_SHIFT_DOWN;
                    fill_next = fill_reg - 1'b1;
                end
                CMD_ASSIGN:
                begin
                    ctrl.op = CELL_WRITE;
                end
                default:
                begin
                    ctrl.op = CELL_HOLD;
                end
            endcase
        end
    end

    assign fill_next_cw = CW'(fill_next);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [7:0] left_data;
        logic [7:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = 8'h00;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = 8'h00;
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        pirb_cell #(
            .WHERE_W (CW),
            .INDEX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .where      (where),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    always_comb
    begin
        rd_c = 8'h00;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_c = rd_c | cell_tap[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_c;
            resolved_reg <= ok ? where[6:0] : 7'd0;
            data_out_reg <= (ok && req.command == CMD_READ) ? rd_c : 8'h00;
            count_reg    <= fill_next_cw[6:0];
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = status_reg;
    assign rsp.resolved_position = resolved_reg;
    assign rsp.data_out          = data_out_reg;
    assign rsp.count             = count_reg;

    `PIRB_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CNT_W'(CAPACITY))
    `PIRB_ASSERT_NEXT(a_insert_grows, clk, rst_n, accept && ok && req.command == CMD_INSERT, fill_reg == CNT_W'($past(fill_reg) + 1'b1))
    `PIRB_ASSERT_NEXT(a_reject_keeps, clk, rst_n, accept && !ok, fill_reg == $past(fill_reg))
    `PIRB_ASSERT_SAME(a_error_zero, clk, rst_n, rsp_valid_reg && status_reg != ST_OK, resolved_reg == 7'd0 && data_out_reg == 8'h00)
    `PIRB_ASSERT_NEXT(a_accept_valid, clk, rst_n, accept, rsp_valid_reg)

endmodule

/* sv/pirb_cell.sv */
// One storage cell of the buffer row: holds a byte and trades it with its neighbors.
// Depends on pirb_pkg for the broadcast control struct.
module pirb_cell
    import pirb_pkg::*;
#(
    parameter int WHERE_W = 7,
    parameter int INDEX   = 0
)
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [WHERE_W-1:0] where,
    input  logic [7:0]         left_data,
    input  logic [7:0]         right_data,
    output logic [7:0]         data,
    output logic [7:0]         tap
);

    localparam logic [WHERE_W-1:0] MY_INDEX = WHERE_W'(INDEX);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       at_where;
    logic       above_where;

    assign at_where    = (where == MY_INDEX);
    assign above_where = (where < MY_INDEX);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_SHIFT_UP:
            begin
                if (at_where)
                begin
                    data_next = ctrl.data;
                end
                else if (above_where)
                begin
                    data_next = left_data;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                if (at_where || above_where)
                begin
                    data_next = right_data;
                end
            end
            CELL_WRITE:
            begin
                if (at_where)
                begin
                    data_next = ctrl.data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = at_where ? data_reg : 8'h00;

endmodule

/* tb/sv/pirb_response_checker.sv */
// Response checker for the positional insert/remove buffer testbench.
// Watches the request and response channels, keeps its own copy of the stored
// list, and compares every response field. Depends on pirb_pkg and pirb_if.
module pirb_response_checker
    import pirb_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic clk,
    input  logic rst_n,
    pirb_req_if  req,
    pirb_rsp_if  rsp,
    output int   fail_count,
    output int   pending,
    output int   level
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] resolved_position;
        logic [7:0] data_out;
        logic [6:0] count;
    } buffer_result_t;

    logic [7:0]     stored_bytes [CAPACITY];
    int             stored_count;
    buffer_result_t pending_responses [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
        level = 0;
        stored_count = 0;
    end

    function automatic buffer_result_t apply_command(logic [1:0] cmd, logic signed [7:0] pos,
                                                     logic [7:0] din);
        buffer_result_t r;
        int p;
        int at;
        int i;
        r = '0;
        p = int'(pos);
        if (cmd == CMD_INSERT)
        begin
            if (p < -1 || p > stored_count)
            begin
                r.status = ST_RANGE;
            end
            else if (stored_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                at = (pos == POS_APPEND) ? stored_count : p;
                for (i = stored_count; i > at; i--)
                begin
                    stored_bytes[i] = stored_bytes[i - 1];
                end
                stored_bytes[at] = din;
                stored_count++;
                r.resolved_position = at[6:0];
            end
        end
        else if (p < 0 || p >= stored_count)
        begin
            r.status = ST_RANGE;
        end
        else
        begin
            r.resolved_position = p[6:0];
            if (cmd == CMD_REMOVE)
            begin
                for (i = p; i + 1 < stored_count; i++)
                begin
                    stored_bytes[i] = stored_bytes[i + 1];
                end
                stored_count--;
            end
            else if (cmd == CMD_ASSIGN)
            begin
                stored_bytes[p] = din;
            end
            else
            begin
                r.data_out = stored_bytes[p];
            end
        end
        r.count = stored_count[6:0];
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        buffer_result_t want;
        if (!rst_n)
        begin
            stored_count = 0;
            pending_responses.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    $display("%0t: response transaction with none expected, actual status %0d",
                             $time, rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = pending_responses.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("resolved_position", want.resolved_position,
                                rsp.resolved_position);
                    check_field("data_out", want.data_out, rsp.data_out);
                    check_field("count", want.count, rsp.count);
                end
            end
            if (req.valid && req.ready)
            begin
                pending_responses.push_back(apply_command(req.command, req.position,
                                                          req.data_in));
            end
        end
        pending = pending_responses.size();
        level = stored_count;
    end

endmodule

/* tb/sv/tb_positional_insert_remove_buffer_unit.sv */
// Testbench top for the positional insert/remove buffer: clock, reset, request
// stimulus, response back-pressure and the verdict. Depends on pirb_pkg, pirb_if,
// the block itself and pirb_response_checker.
module tb_positional_insert_remove_buffer_unit
    import pirb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 235;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   level;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;

    pirb_req_if req_ch ();
    pirb_rsp_if rsp_ch ();

    positional_insert_remove_buffer_unit #(.CAPACITY(CAPACITY)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pirb_response_checker #(.CAPACITY(CAPACITY)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .level      (level)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Leaves the clock at a falling edge, after the idle gap if one is drawn.
    task automatic wait_slot();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
    endtask

    task automatic offer(logic [1:0] cmd, logic signed [7:0] pos, logic [7:0] din);
        req_ch.valid    <= 1'b1;
        req_ch.command  <= cmd;
        req_ch.position <= pos;
        req_ch.data_in  <= din;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    task automatic send(logic [1:0] cmd, logic signed [7:0] pos, logic [7:0] din);
        wait_slot();
        offer(cmd, pos, din);
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_random(int idx);
        logic [1:0]        cmd;
        logic signed [7:0] pos;
        int                r;
        int                mode;
        wait_slot();
        mode = (idx / 100) % 3;
        r = $urandom_range(0, 99);
        if (mode == 0)
        begin
            cmd = (r < 85) ? CMD_INSERT : (r < 90) ? CMD_REMOVE : (r < 95) ? CMD_ASSIGN : CMD_READ;
        end
        else if (mode == 1)
        begin
            cmd = (r < 5) ? CMD_INSERT : (r < 85) ? CMD_REMOVE : (r < 92) ? CMD_ASSIGN : CMD_READ;
        end
        else
        begin
            cmd = (r < 25) ? CMD_INSERT : (r < 50) ? CMD_REMOVE : (r < 75) ? CMD_ASSIGN : CMD_READ;
        end
        if ($urandom_range(0, 99) < 85)
        begin
            if (cmd == CMD_INSERT)
            begin
                pos = ($urandom_range(0, 9) == 0) ? POS_APPEND : 8'($urandom_range(0, level));
            end
            else
            begin
                pos = (level == 0) ? 8'sd0 : 8'($urandom_range(0, level - 1));
            end
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: pos = 8'(level);
                1: pos = POS_APPEND;
                2: pos = -8'sd2;
                3: pos = 8'(CAPACITY);
                default: pos = 8'($urandom_range(0, 255));
            endcase
        end
        offer(cmd, pos, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_INSERT;
        req_ch.position = '0;
        req_ch.data_in = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send(CMD_READ, 8'sd0, 8'h00);
        send(CMD_REMOVE, 8'sd0, 8'h00);
        send(CMD_ASSIGN, 8'sd0, 8'h11);
        send(CMD_INSERT, 8'sd1, 8'h22);
        send(CMD_INSERT, -8'sd2, 8'h33);
        send(CMD_INSERT, -8'sd128, 8'h44);
        send(CMD_INSERT, 8'sd0, 8'hFF);
        send(CMD_INSERT, POS_APPEND, 8'h00);
        send(CMD_INSERT, 8'sd0, 8'h5A);
        send(CMD_INSERT, 8'sd2, 8'hA5);
        send(CMD_READ, 8'sd0, 8'h00);
        send(CMD_READ, 8'sd1, 8'h00);
        send(CMD_READ, 8'sd2, 8'h00);
        send(CMD_READ, 8'sd3, 8'hFF);
        send(CMD_READ, 8'sd4, 8'h00);
        send(CMD_READ, -8'sd1, 8'h00);
        send(CMD_READ, 8'sd127, 8'h00);
        send(CMD_ASSIGN, 8'sd3, 8'h81);
        send(CMD_ASSIGN, 8'sd4, 8'h7F);
        send(CMD_REMOVE, 8'sd1, 8'h00);
        send(CMD_REMOVE, 8'sd2, 8'h00);
        send(CMD_REMOVE, -8'sd1, 8'h00);
        send(CMD_READ, 8'sd0, 8'h00);
        send(CMD_READ, 8'sd1, 8'h00);
        send(CMD_INSERT, 8'sd2, 8'h7E);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random(phase * PHASE_ITEMS + i);
                if (phase == 0 && i == 120)
                begin
                    hold_cycles = 300;
                end
            end
            drain();
        end

        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
